// ===== sv/hc05_pkg.sv =====
// ----------------------------------------------------------------------------
// hc05_pkg: shared types and constants of the 6805-style execute unit
// Operation codes, condition code bit positions and reset values.
// ----------------------------------------------------------------------------
package hc05_pkg;

  // Operation codes, densely numbered; unlisted codes act as NOP
  typedef enum logic [5:0] {
    OP_NOP   = 6'd0,  OP_ADC   = 6'd1,  OP_ADD   = 6'd2,  OP_AND   = 6'd3,
    OP_ASL   = 6'd4,  OP_ASR   = 6'd5,  OP_BIT   = 6'd6,  OP_BCLR  = 6'd7,
    OP_BSET  = 6'd8,  OP_BRCLR = 6'd9,  OP_BRSET = 6'd10, OP_CLC   = 6'd11,
    OP_CLI   = 6'd12, OP_CLR   = 6'd13, OP_CMP   = 6'd14, OP_COM   = 6'd15,
    OP_CPX   = 6'd16, OP_DEC   = 6'd17, OP_EOR   = 6'd18, OP_INC   = 6'd19,
    OP_LDA   = 6'd20, OP_LDX   = 6'd21, OP_LSR   = 6'd22, OP_MUL   = 6'd23,
    OP_NEG   = 6'd24, OP_ORA   = 6'd25, OP_ROL   = 6'd26, OP_ROR   = 6'd27,
    OP_SBC   = 6'd28, OP_SEC   = 6'd29, OP_SEI   = 6'd30, OP_STA   = 6'd31,
    OP_STOP  = 6'd32, OP_STX   = 6'd33, OP_SUB   = 6'd34, OP_TAX   = 6'd35,
    OP_TST   = 6'd36, OP_TXA   = 6'd37, OP_WAIT  = 6'd38, OP_BRA   = 6'd39,
    OP_BRN   = 6'd40, OP_BHI   = 6'd41, OP_BLS   = 6'd42, OP_BCC   = 6'd43,
    OP_BCS   = 6'd44, OP_BNE   = 6'd45, OP_BEQ   = 6'd46, OP_BHCC  = 6'd47,
    OP_BHCS  = 6'd48, OP_BPL   = 6'd49, OP_BMI   = 6'd50, OP_BMC   = 6'd51,
    OP_BMS   = 6'd52, OP_BIL   = 6'd53, OP_BIH   = 6'd54
  } op_t;

  // Stored condition code bits (top three bits are constant ones)
  typedef struct packed {
    logic h;
    logic i;
    logic n;
    logic z;
    logic c;
  } ccr_t;

  localparam logic [2:0] CC_TOP = 3'b111;
  localparam ccr_t CCR_RESET = '{h: 1'b0, i: 1'b1, n: 1'b0, z: 1'b0, c: 1'b0};

  // Halt status codes
  localparam logic [1:0] HALT_RUN  = 2'd0;
  localparam logic [1:0] HALT_STOP = 2'd1;
  localparam logic [1:0] HALT_WAIT = 2'd2;

endpackage

// ===== sv/hc05_alu_and_flag_execute.sv =====
// ----------------------------------------------------------------------------
// hc05_alu_and_flag_execute: ALU and condition code execute unit
// Holds A, X, CCR and the stop/wait marks; one operation per beat.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; throughput: one beat per
//   cycle while the result channel does not stall, set by the single ALU pass
//   from the input register to the result register.
// Reset: A and X clear, CCR reads 0xE8 (interrupt mask set), stop and wait
//   marks clear, both pipeline registers empty.
module hc05_alu_and_flag_execute
  import hc05_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [5:0] in_command,
  input  logic [7:0] in_operand,
  input  logic [2:0] in_bit_number,
  input  logic       in_irq_level,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_write_value,
  output logic       out_branch_taken,
  output logic [7:0] out_acc_out,
  output logic [7:0] out_index_out,
  output logic [7:0] out_flags_out,
  output logic [1:0] out_halt_status
);

  // input register
  logic       in_vld_r;
  logic [5:0] cmd_r;
  logic [7:0] opd_r;
  logic [2:0] bitn_r;
  logic       irq_r;

  // architectural state
  logic [7:0] acc_r, acc_nxt;
  logic [7:0] idx_r, idx_nxt;
  ccr_t       ccr_r, ccr_nxt;
  logic       stop_r, stop_nxt;
  logic       wait_r, wait_nxt;

  // result register
  logic       out_vld_r;
  logic [7:0] wv_r, wv_nxt;
  logic       br_r, br_nxt;
  logic [1:0] halt_r, halt_nxt;

  logic       adv;
  logic       fire;
  logic [7:0] bmask;
  logic [8:0] add9;
  logic [4:0] addh;
  logic [8:0] sub9;
  logic [7:0] sub_a;
  logic       cin;
  logic [15:0] prod;

  // advance when the result register is empty or being drained
  assign adv      = !out_vld_r || !out_stall;
  assign fire     = adv && in_vld_r;
  assign in_stall = in_vld_r && !adv;

  // hold or load the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      cmd_r  <= in_command;
      opd_r  <= in_operand;
      bitn_r <= in_bit_number;
      irq_r  <= in_irq_level;
    end
  end

  // shared arithmetic: adder, subtractor, multiplier
  assign bmask = 8'd1 << bitn_r;
  assign cin   = ((cmd_r == OP_ADC) || (cmd_r == OP_SBC)) ? ccr_r.c : 1'b0;
  assign add9  = {1'b0, acc_r} + {1'b0, opd_r} + {8'd0, cin};
  assign addh  = {1'b0, acc_r[3:0]} + {1'b0, opd_r[3:0]} + {4'd0, cin};
  assign sub_a = (cmd_r == OP_CPX) ? idx_r : acc_r;
  assign sub9  = {1'b0, sub_a} - {1'b0, opd_r} - {8'd0, cin};
  assign prod  = acc_r * idx_r;

  // execute one operation
  always_comb begin
    acc_nxt  = acc_r;
    idx_nxt  = idx_r;
    ccr_nxt  = ccr_r;
    stop_nxt = stop_r;
    wait_nxt = wait_r;
    wv_nxt   = opd_r;
    br_nxt   = 1'b0;
    case (cmd_r)
      OP_ADC, OP_ADD: begin
        acc_nxt   = add9[7:0];
        ccr_nxt.h = addh[4];
        ccr_nxt.n = add9[7];
        ccr_nxt.z = (add9[7:0] == 8'd0);
        ccr_nxt.c = add9[8];
      end
      OP_SUB, OP_SBC, OP_CMP, OP_CPX: begin
        if ((cmd_r == OP_SUB) || (cmd_r == OP_SBC)) begin
          acc_nxt = sub9[7:0];
        end
        ccr_nxt.n = sub9[7];
        ccr_nxt.z = (sub9[7:0] == 8'd0);
        ccr_nxt.c = sub9[8];
      end
      OP_AND: begin
        acc_nxt   = acc_r & opd_r;
        ccr_nxt.n = acc_nxt[7];
        ccr_nxt.z = (acc_nxt == 8'd0);
      end
      OP_ORA: begin
        acc_nxt   = acc_r | opd_r;
        ccr_nxt.n = acc_nxt[7];
        ccr_nxt.z = (acc_nxt == 8'd0);
      end
      OP_EOR: begin
        acc_nxt   = acc_r ^ opd_r;
        ccr_nxt.n = acc_nxt[7];
        ccr_nxt.z = (acc_nxt == 8'd0);
      end
      OP_BIT: begin
        ccr_nxt.n = acc_r[7] & opd_r[7];
        ccr_nxt.z = ((acc_r & opd_r) == 8'd0);
      end
      OP_LDA: begin
        acc_nxt   = opd_r;
        ccr_nxt.n = opd_r[7];
        ccr_nxt.z = (opd_r == 8'd0);
      end
      OP_LDX: begin
        idx_nxt   = opd_r;
        ccr_nxt.n = opd_r[7];
        ccr_nxt.z = (opd_r == 8'd0);
      end
      OP_TST: begin
        ccr_nxt.n = opd_r[7];
        ccr_nxt.z = (opd_r == 8'd0);
      end
      OP_STA: begin
        wv_nxt    = acc_r;
        ccr_nxt.n = acc_r[7];
        ccr_nxt.z = (acc_r == 8'd0);
      end
      OP_STX: begin
        wv_nxt    = idx_r;
        ccr_nxt.n = idx_r[7];
        ccr_nxt.z = (idx_r == 8'd0);
      end
      OP_ASL, OP_ROL: begin
        wv_nxt    = {opd_r[6:0], (cmd_r == OP_ROL) ? ccr_r.c : 1'b0};
        ccr_nxt.n = wv_nxt[7];
        ccr_nxt.z = (wv_nxt == 8'd0);
        ccr_nxt.c = opd_r[7];
      end
      OP_ASR, OP_ROR, OP_LSR: begin
        case (cmd_r)
          OP_ASR:  wv_nxt = {opd_r[7], opd_r[7:1]};
          OP_ROR:  wv_nxt = {ccr_r.c, opd_r[7:1]};
          default: wv_nxt = {1'b0, opd_r[7:1]};
        endcase
        ccr_nxt.n = wv_nxt[7];
        ccr_nxt.z = (wv_nxt == 8'd0);
        ccr_nxt.c = opd_r[0];
      end
      OP_CLR: begin
        wv_nxt    = 8'd0;
        ccr_nxt.n = 1'b0;
        ccr_nxt.z = 1'b1;
      end
      OP_COM: begin
        wv_nxt    = ~opd_r;
        ccr_nxt.n = wv_nxt[7];
        ccr_nxt.z = (wv_nxt == 8'd0);
        ccr_nxt.c = 1'b1;
      end
      OP_NEG: begin
        wv_nxt    = 8'd0 - opd_r;
        ccr_nxt.n = wv_nxt[7];
        ccr_nxt.z = (wv_nxt == 8'd0);
        ccr_nxt.c = (wv_nxt != 8'd0);
      end
      OP_INC, OP_DEC: begin
        wv_nxt    = (cmd_r == OP_INC) ? opd_r + 8'd1 : opd_r - 8'd1;
        ccr_nxt.n = wv_nxt[7];
        ccr_nxt.z = (wv_nxt == 8'd0);
      end
      OP_MUL: begin
        idx_nxt   = prod[15:8];
        acc_nxt   = prod[7:0];
        ccr_nxt.h = 1'b0;
        ccr_nxt.c = 1'b0;
      end
      OP_BCLR: wv_nxt = opd_r & ~bmask;
      OP_BSET: wv_nxt = opd_r | bmask;
      OP_BRCLR, OP_BRSET: begin
        ccr_nxt.c = ((opd_r & bmask) != 8'd0);
        br_nxt    = (cmd_r == OP_BRSET) ? ccr_nxt.c : !ccr_nxt.c;
      end
      OP_CLC: ccr_nxt.c = 1'b0;
      OP_SEC: ccr_nxt.c = 1'b1;
      OP_CLI: ccr_nxt.i = 1'b0;
      OP_SEI: ccr_nxt.i = 1'b1;
      OP_TAX: idx_nxt = acc_r;
      OP_TXA: acc_nxt = idx_r;
      OP_STOP: begin
        ccr_nxt.i = 1'b0;
        stop_nxt  = 1'b1;
      end
      OP_WAIT: begin
        ccr_nxt.i = 1'b0;
        wait_nxt  = 1'b1;
      end
      OP_BRA:  br_nxt = 1'b1;
      OP_BRN:  br_nxt = 1'b0;
      OP_BHI:  br_nxt = !ccr_r.c && !ccr_r.z;
      OP_BLS:  br_nxt = ccr_r.c || ccr_r.z;
      OP_BCC:  br_nxt = !ccr_r.c;
      OP_BCS:  br_nxt = ccr_r.c;
      OP_BNE:  br_nxt = !ccr_r.z;
      OP_BEQ:  br_nxt = ccr_r.z;
      OP_BHCC: br_nxt = !ccr_r.h;
      OP_BHCS: br_nxt = ccr_r.h;
      OP_BPL:  br_nxt = !ccr_r.n;
      OP_BMI:  br_nxt = ccr_r.n;
      OP_BMC:  br_nxt = !ccr_r.i;
      OP_BMS:  br_nxt = ccr_r.i;
      OP_BIL:  br_nxt = !irq_r;
      OP_BIH:  br_nxt = irq_r;
      default: ;
    endcase
    // stop wins over wait
    if (stop_nxt) begin
      halt_nxt = HALT_STOP;
    end else if (wait_nxt) begin
      halt_nxt = HALT_WAIT;
    end else begin
      halt_nxt = HALT_RUN;
    end
  end

  // advance state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= 8'd0;
      idx_r     <= 8'd0;
      ccr_r     <= CCR_RESET;
      stop_r    <= 1'b0;
      wait_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
      if (fire) begin
        acc_r  <= acc_nxt;
        idx_r  <= idx_nxt;
        ccr_r  <= ccr_nxt;
        stop_r <= stop_nxt;
        wait_r <= wait_nxt;
      end
    end
    if (fire) begin
      wv_r   <= wv_nxt;
      br_r   <= br_nxt;
      halt_r <= halt_nxt;
    end
  end

  // drive the result beat; A, X and CCR are the live state after this beat
  assign out_valid        = out_vld_r;
  assign out_write_value  = wv_r;
  assign out_branch_taken = br_r;
  assign out_acc_out      = acc_r;
  assign out_index_out    = idx_r;
  assign out_flags_out    = {CC_TOP, ccr_r};
  assign out_halt_status  = halt_r;

endmodule
